### src/mwo_pkg.sv
// Shared types, constants and tables for the mecanum wheel odometry core.
package mwo_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int DX_SHIFT     = 47 - FRAC_BITS;
    localparam int VT_SHIFT     = 31 - FRAC_BITS;

    localparam int DVD_W = 104;   // divider dividend and quotient width
    localparam int DVS_W = 66;    // divider divisor width
    localparam int MAG_W = 34;    // magnitude of a four-wheel count sum

    localparam logic [31:0] TWO_PI_Q29      = 32'd3373259426;
    localparam logic [31:0] CORDIC_GAIN_Q31 = 32'd1304065748;
    localparam logic [19:0] US_PER_S        = 20'd1000000;

    localparam logic [1:0] CFG_TICKS      = 2'd0;
    localparam logic [1:0] CFG_RADIUS     = 2'd1;
    localparam logic [1:0] CFG_HALF_TRACK = 2'd2;

    typedef struct packed {
        logic [15:0] ticks;       // zero already replaced by one
        logic [15:0] radius;
        logic [17:0] half_track;  // zero already replaced by one
    } t_cfg;

    typedef struct packed {
        logic             sx_neg;
        logic [MAG_W-1:0] sx_mag;
        logic             sy_neg;
        logic [MAG_W-1:0] sy_mag;
        logic             st_neg;
        logic [MAG_W-1:0] st_mag;
        logic [31:0]      dt;
        logic [31:0]      stamp;
    } t_job;

    typedef struct packed {
        logic [31:0] time_us;
        logic [31:0] turn_rate;
        logic [31:0] vel_y;
        logic [31:0] vel_x;
        logic [15:0] heading;
        logic [31:0] pos_y;
        logic [31:0] pos_x;
    } t_result;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [31:0] atan_turns(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    // Saturate a magnitude with its sign into a signed 32-bit word.
    function automatic logic [31:0] sat_signed(input logic [DVD_W-1:0] m, input logic neg);
        logic [31:0] v;
        if (neg) begin
            if ((|m[DVD_W-1:32]) || (m[31:0] > 32'h8000_0000)) v = 32'h8000_0000;
            else v = 32'd0 - m[31:0];
        end else begin
            if ((|m[DVD_W-1:31])) v = 32'h7FFF_FFFF;
            else v = m[31:0];
        end
        return v;
    endfunction

    function automatic logic [31:0] wrap_signed(input logic [31:0] m, input logic neg);
        return neg ? (32'd0 - m) : m;
    endfunction

endpackage

### src/mwo_div.sv
// Restoring divider, one quotient bit per cycle.
module mwo_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mwo_pkg::DVD_W-1:0] i_dividend,
    input  logic [mwo_pkg::DVS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [mwo_pkg::DVD_W-1:0] o_quotient
);
    import mwo_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W:0]   r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0] w_rem_sh;
    logic           w_qbit;

    assign w_rem_sh = {r_rem[DVS_W-1:0], r_dvd[DVD_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_dvd  <= i_dividend;
                r_dvs  <= i_divisor;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= w_qbit ? (w_rem_sh - {1'b0, r_dvs}) : w_rem_sh;
                r_dvd <= {r_dvd[DVD_W-2:0], w_qbit};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;
endmodule

### src/mwo_fifo.sv
// Two-entry request queue between the front end and the back end.
module mwo_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mwo_pkg::t_job i_job,
    input  logic          i_pop,
    output mwo_pkg::t_job o_job,
    output logic          o_full,
    output logic          o_empty
);
    import mwo_pkg::*;

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wp] <= i_job;
                r_wp        <= ~r_wp;
            end
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    assign o_job   = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
endmodule

### src/mwo_front.sv
// Front end: accept samples, latch previous counts, form wheel sums and elapsed time.
module mwo_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [159:0]  i_data,
    input  logic          i_full,
    output logic          o_push,
    output mwo_pkg::t_job o_job
);
    import mwo_pkg::*;

    logic        r_primed;
    logic [31:0] r_prev [4];
    logic [31:0] r_prev_time;

    logic [31:0] w_cnt [4];
    logic [34:0] w_d   [4];
    logic [34:0] w_sx, w_sy, w_st;
    logic        w_accept;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_cnt[k] = i_data[32*k +: 32];
            w_d[k]   = 35'($signed(w_cnt[k] - r_prev[k]));
        end
        w_sx = w_d[0] + w_d[1] + w_d[2] + w_d[3];
        w_sy = w_d[1] + w_d[2] - w_d[0] - w_d[3];
        w_st = w_d[1] + w_d[3] - w_d[0] - w_d[2];

        o_job.sx_neg = w_sx[34];
        o_job.sx_mag = MAG_W'(w_sx[34] ? (35'd0 - w_sx) : w_sx);
        o_job.sy_neg = w_sy[34];
        o_job.sy_mag = MAG_W'(w_sy[34] ? (35'd0 - w_sy) : w_sy);
        o_job.st_neg = w_st[34];
        o_job.st_mag = MAG_W'(w_st[34] ? (35'd0 - w_st) : w_st);
        o_job.dt     = i_data[159:128] - r_prev_time;
        o_job.stamp  = i_data[159:128];
    end

    // The priming sample never needs queue space.
    assign o_ready  = !r_primed || !i_full;
    assign w_accept = i_valid && o_ready;
    assign o_push   = w_accept && r_primed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (w_accept) begin
            r_primed <= 1'b1;
            for (int k = 0; k < 4; k++) r_prev[k] <= w_cnt[k];
            r_prev_time <= i_data[159:128];
        end
    end
endmodule

### src/mwo_back.sv
// Back end: sequenced multiplies, shared divider, CORDIC rotation and pose update.
module mwo_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mwo_pkg::t_cfg    i_cfg,
    input  mwo_pkg::t_job    i_job,
    input  logic             i_job_valid,
    output logic             o_job_pop,
    output mwo_pkg::t_result o_res,
    output logic             o_res_valid,
    input  logic             i_res_ready
);
    import mwo_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_ISSUE, S_MUL, S_DIV, S_ROT, S_GAIN_X, S_GAIN_Y, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        ST_TKDT, ST_LT, ST_LTDT, ST_XR, ST_XP, ST_XD, ST_XM, ST_XV,
        ST_YR, ST_YP, ST_YD, ST_YM, ST_YV, ST_TR, ST_TP, ST_TM, ST_TV,
        ST_TH, ST_ROT
    } t_step;

    t_state r_state;
    t_step  r_step;
    t_job   r_job;

    // shared multiplier: 32-bit slice of A times B per cycle
    logic [127:0]     r_ma;
    logic [MAG_W-1:0] r_mb;
    logic [127:0]     r_acc;
    logic [1:0]       r_mk;
    logic [65:0]      w_pp;
    logic [127:0]     n_acc;

    logic             r_dstart;
    logic [DVD_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic             w_ddone;
    logic [DVD_W-1:0] w_q;

    logic [47:0] r_tkdt;
    logic [33:0] r_lt;
    logic [65:0] r_ltdt;
    logic [81:0] r_p;
    logic [49:0] r_rst;
    logic [31:0] r_dx, r_dy, r_vx, r_vy, r_vt, r_dth;

    logic signed [35:0] r_cx, r_cy;
    logic signed [31:0] r_cz;
    logic [4:0]         r_ci;
    logic signed [67:0] r_gp;
    logic [31:0]        r_rx;

    logic [31:0] r_pose_x, r_pose_y, r_head;
    logic        r_res_valid;
    t_result     r_res;

    logic [31:0]        w_hq;
    logic [1:0]         w_quarter;
    logic signed [35:0] w_x0, w_y0, w_xs, w_ys;
    logic [31:0]        w_head_n;

    assign w_pp  = r_ma[{r_mk, 5'b0} +: 32] * r_mb;
    assign n_acc = r_acc + (128'(w_pp) << {r_mk, 5'b0});

    assign w_hq      = r_head + 32'h2000_0000;
    assign w_quarter = w_hq[31:30];
    assign w_x0      = 36'($signed(r_dx));
    assign w_y0      = 36'($signed(r_dy));
    assign w_xs      = r_cx >>> r_ci;
    assign w_ys      = r_cy >>> r_ci;
    assign w_head_n  = r_head + r_dth;

    mwo_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_dstart),
        .i_dividend (r_dvd),
        .i_divisor  (r_dvs),
        .o_done     (w_ddone),
        .o_quotient (w_q)
    );

    assign o_job_pop   = (r_state == S_IDLE) && i_job_valid;
    assign o_res       = r_res;
    assign o_res_valid = r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= ST_TKDT;
            r_dstart    <= 1'b0;
            r_res_valid <= 1'b0;
            r_pose_x    <= '0;
            r_pose_y    <= '0;
            r_head      <= '0;
            r_mk        <= '0;
        end else begin
            r_dstart <= 1'b0;
            if (r_res_valid && i_res_ready) r_res_valid <= 1'b0;

            unique case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_job   <= i_job;
                        r_step  <= ST_TKDT;
                        r_state <= S_ISSUE;
                    end
                end

                S_MUL: begin
                    r_acc <= n_acc;
                    r_mk  <= r_mk + 2'd1;
                    if (r_mk == 2'd3) r_state <= S_ISSUE;
                end

                S_DIV: begin
                    if (w_ddone) r_state <= S_ISSUE;
                end

                // Take the previous result, then launch the next operation.
                S_ISSUE: begin
                    r_acc <= '0;
                    r_mk  <= '0;
                    r_state <= S_MUL;
                    unique case (r_step)
                        ST_TKDT: begin
                            r_ma <= 128'(r_job.dt);
                            r_mb <= MAG_W'(i_cfg.ticks);
                            r_step <= ST_LT;
                        end
                        ST_LT: begin
                            r_tkdt <= r_acc[47:0];
                            r_ma <= 128'(i_cfg.half_track);
                            r_mb <= MAG_W'(i_cfg.ticks);
                            r_step <= ST_LTDT;
                        end
                        ST_LTDT: begin
                            r_lt <= r_acc[33:0];
                            r_ma <= 128'(r_acc[33:0]);
                            r_mb <= MAG_W'(r_job.dt);
                            r_step <= ST_XR;
                        end
                        ST_XR: begin
                            r_ltdt <= r_acc[65:0];
                            r_ma <= 128'(r_job.sx_mag);
                            r_mb <= MAG_W'(i_cfg.radius);
                            r_step <= ST_XP;
                        end
                        ST_XP, ST_YP: begin
                            r_ma <= 128'(r_acc[49:0]);
                            r_mb <= MAG_W'(TWO_PI_Q29);
                            r_step <= (r_step == ST_XP) ? ST_XD : ST_YD;
                        end
                        ST_XD, ST_YD: begin
                            r_p      <= r_acc[81:0];
                            r_dvd    <= DVD_W'(r_acc[81:0]);
                            r_dvs    <= DVS_W'(i_cfg.ticks);
                            r_dstart <= 1'b1;
                            r_state  <= S_DIV;
                            r_step   <= (r_step == ST_XD) ? ST_XM : ST_YM;
                        end
                        ST_XM: begin
                            r_dx <= wrap_signed(w_q[DX_SHIFT +: 32], r_job.sx_neg);
                            r_ma <= 128'(r_p);
                            r_mb <= MAG_W'(US_PER_S);
                            r_step <= ST_XV;
                        end
                        ST_YM: begin
                            r_dy <= wrap_signed(w_q[DX_SHIFT +: 32], r_job.sy_neg);
                            r_ma <= 128'(r_p);
                            r_mb <= MAG_W'(US_PER_S);
                            r_step <= ST_YV;
                        end
                        ST_XV, ST_YV: begin
                            r_dvd    <= r_acc[DVD_W-1:0];
                            r_dvs    <= DVS_W'(r_tkdt);
                            r_dstart <= 1'b1;
                            r_state  <= S_DIV;
                            r_step   <= (r_step == ST_XV) ? ST_YR : ST_TR;
                        end
                        ST_YR: begin
                            r_vx <= sat_signed(w_q >> DX_SHIFT, r_job.sx_neg);
                            r_ma <= 128'(r_job.sy_mag);
                            r_mb <= MAG_W'(i_cfg.radius);
                            r_step <= ST_YP;
                        end
                        ST_TR: begin
                            r_vy <= sat_signed(w_q >> DX_SHIFT, r_job.sy_neg);
                            r_ma <= 128'(r_job.st_mag);
                            r_mb <= MAG_W'(i_cfg.radius);
                            r_step <= ST_TP;
                        end
                        ST_TP: begin
                            r_rst <= r_acc[49:0];
                            r_ma  <= 128'(r_acc[49:0]);
                            r_mb  <= MAG_W'(TWO_PI_Q29);
                            r_step <= ST_TM;
                        end
                        ST_TM: begin
                            r_ma <= 128'(r_acc[81:0]);
                            r_mb <= MAG_W'(US_PER_S);
                            r_step <= ST_TV;
                        end
                        ST_TV: begin
                            r_dvd    <= r_acc[DVD_W-1:0];
                            r_dvs    <= r_ltdt;
                            r_dstart <= 1'b1;
                            r_state  <= S_DIV;
                            r_step   <= ST_TH;
                        end
                        ST_TH: begin
                            r_vt     <= sat_signed(w_q >> VT_SHIFT, r_job.st_neg);
                            r_dvd    <= DVD_W'({r_rst, 30'b0});
                            r_dvs    <= DVS_W'(r_lt);
                            r_dstart <= 1'b1;
                            r_state  <= S_DIV;
                            r_step   <= ST_ROT;
                        end
                        ST_ROT: begin
                            r_dth <= wrap_signed(w_q[31:0], r_job.st_neg);
                            r_cz  <= $signed(r_head - {w_quarter, 30'b0});
                            r_ci  <= '0;
                            unique case (w_quarter)
                                2'd1: begin r_cx <= -w_y0; r_cy <= w_x0;  end
                                2'd2: begin r_cx <= -w_x0; r_cy <= -w_y0; end
                                2'd3: begin r_cx <= w_y0;  r_cy <= -w_x0; end
                                default: begin r_cx <= w_x0; r_cy <= w_y0; end
                            endcase
                            r_state <= S_ROT;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end

                S_ROT: begin
                    if (!r_cz[31]) begin
                        r_cx <= r_cx - w_ys;
                        r_cy <= r_cy + w_xs;
                        r_cz <= r_cz - $signed(atan_turns(r_ci));
                    end else begin
                        r_cx <= r_cx + w_ys;
                        r_cy <= r_cy - w_xs;
                        r_cz <= r_cz + $signed(atan_turns(r_ci));
                    end
                    r_ci <= r_ci + 5'd1;
                    if (r_ci == 5'(CORDIC_STEPS - 1)) r_state <= S_GAIN_X;
                end

                S_GAIN_X: begin
                    r_gp    <= r_cx * $signed({1'b0, CORDIC_GAIN_Q31});
                    r_state <= S_GAIN_Y;
                end

                S_GAIN_Y: begin
                    r_rx    <= r_gp[62:31];
                    r_gp    <= r_cy * $signed({1'b0, CORDIC_GAIN_Q31});
                    r_state <= S_FIN;
                    r_step  <= ST_TKDT;
                end

                // Hold the pose update until the output register is free.
                S_FIN: begin
                    if (!r_res_valid || i_res_ready) begin
                        r_pose_x          <= r_pose_x + r_rx;
                        r_pose_y          <= r_pose_y + r_gp[62:31];
                        r_head            <= w_head_n;
                        r_res.pos_x       <= r_pose_x + r_rx;
                        r_res.pos_y       <= r_pose_y + r_gp[62:31];
                        r_res.heading     <= w_head_n[31:16];
                        r_res.vel_x       <= (r_job.dt == 32'd0) ? 32'd0 : r_vx;
                        r_res.vel_y       <= (r_job.dt == 32'd0) ? 32'd0 : r_vy;
                        r_res.turn_rate   <= (r_job.dt == 32'd0) ? 32'd0 : r_vt;
                        r_res.time_us     <= r_job.stamp;
                        r_res_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### src/mecanum_wheel_odometry_core.sv
// Top level of the mecanum four-wheel odometry core.
//
// Input stream: one request per sample, four cumulative encoder counts and a
// microsecond timestamp. The first request after reset only latches counts and
// time and yields no result; every later one yields one result on the output
// stream: world pose (Q15.16, wrapping), heading as a 16-bit binary angle,
// body velocities and turn rate (Q15.16, saturating) and the sample's time.
// Config channel: write ticks per revolution (index 0), wheel radius Q0.16
// (index 1) and half-track sum Q2.16 (index 2) while the core is idle; other
// indexes are dropped. The channel is always ready.
// Sequencing: the back end takes one sample at a time and runs twelve multiplies,
// six divides on one shared radix-2 divider and 16 CORDIC iterations. A two-entry
// queue lets the front accept up to two more samples while the back works.
// Reset: synchronous, active low; clears priming, pose, heading and the queue
// and restores register defaults. When the receiver stalls, the result holds
// in the output register, the back end waits, the queue fills and then the
// input's tready drops.
module mecanum_wheel_odometry_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] front_left_count, [63:32] front_right_count,
    // [95:64] rear_left_count, [127:96] rear_right_count, [159:128] sample_time_us
    input  logic [159:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] position_x, [63:32] position_y, [79:64] heading_angle,
    // [111:80] body_velocity_x, [143:112] body_velocity_y,
    // [175:144] turn_rate, [207:176] result_time_us
    output logic [207:0] o_m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [17:0]  i_cfg_data
);
    import mwo_pkg::*;

    logic [15:0] r_ticks;
    logic [15:0] r_radius;
    logic [17:0] r_half_track;
    t_cfg        w_cfg;

    logic    w_push, w_pop, w_full, w_empty;
    t_job    w_job_in, w_job_out;
    t_result w_res;

    // Configuration registers; zero ticks or half track act as one.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks      <= 16'd500;
            r_radius     <= 16'd3277;
            r_half_track <= 18'd22938;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_TICKS:      r_ticks      <= i_cfg_data[15:0];
                CFG_RADIUS:     r_radius     <= i_cfg_data[15:0];
                CFG_HALF_TRACK: r_half_track <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_cfg.ticks      = (r_ticks == 16'd0) ? 16'd1 : r_ticks;
    assign w_cfg.radius     = r_radius;
    assign w_cfg.half_track = (r_half_track == 18'd0) ? 18'd1 : r_half_track;

    mwo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_job   (w_job_in)
    );

    mwo_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    mwo_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_job       (w_job_out),
        .i_job_valid (!w_empty),
        .o_job_pop   (w_pop),
        .o_res       (w_res),
        .o_res_valid (o_m_axis_tvalid),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {w_res.time_us, w_res.turn_rate, w_res.vel_y, w_res.vel_x,
                             w_res.heading, w_res.pos_y, w_res.pos_x};

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("queue read while empty");

    a_ready_when_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_full |-> o_s_axis_tready)
        else $error("input stalled with queue room");
`endif
endmodule

### tb/sv/mecanum_wheel_odometry_core_test.sv
// Self-checking testbench for the mecanum wheel odometry core: predictor, scoreboard, stimulus.
`timescale 1ns / 1ps

import mwo_pkg::*;

// Pose predictor plus the store of expected results.
class odometry_scoreboard;
    logic [15:0] ticks;
    logic [15:0] radius;
    logic [17:0] half_track;
    bit          primed;
    logic [31:0] last_count [4];
    logic [31:0] last_stamp;
    logic [31:0] pose_x;
    logic [31:0] pose_y;
    logic [31:0] heading;
    t_result     expected_q [$];
    int          failures;

    function new();
        clear();
        failures = 0;
    endfunction

    function void clear();
        ticks      = 16'd500;
        radius     = 16'd3277;
        half_track = 18'd22938;
        primed     = 0;
        pose_x     = '0;
        pose_y     = '0;
        heading    = '0;
        expected_q.delete();
    endfunction

    function void write_reg(logic [1:0] idx, logic [17:0] val);
        case (idx)
            CFG_TICKS:      ticks      = val[15:0];
            CFG_RADIUS:     radius     = val[15:0];
            CFG_HALF_TRACK: half_track = val;
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function logic [31:0] clamp32(logic [127:0] m, bit neg);
        if (neg) begin
            if (m > 128'h8000_0000) return 32'h8000_0000;
            return 32'd0 - m[31:0];
        end
        if (m > 128'h7FFF_FFFF) return 32'h7FFF_FFFF;
        return m[31:0];
    endfunction

    function logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // Turn (px, py) by angle a in 2^-32 turn units: exact quarter, then CORDIC.
    function void turn_vector(logic [31:0] px, logic [31:0] py, logic [31:0] a,
                              output logic [31:0] ox, output logic [31:0] oy);
        longint      atan_tab [24] = '{
            64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
            64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
            64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
            64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
            64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};
        longint      x, y, t, z, xs, ys, gain;
        logic [31:0] sum;
        logic [1:0]  quarter;
        logic [31:0] resid;
        x = longint'($signed(px));
        y = longint'($signed(py));
        sum = a + 32'h2000_0000;
        quarter = sum[31:30];
        resid = a - {quarter, 30'b0};
        z = longint'($signed(resid));
        case (quarter)
            2'd1: begin t = x; x = -y; y = t; end
            2'd2: begin x = -x; y = -y; end
            2'd3: begin t = x; x = y; y = -t; end
            default: ;
        endcase
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z -= atan_tab[i];
            end else begin
                x = x + ys; y = y - xs; z += atan_tab[i];
            end
        end
        gain = longint'(CORDIC_GAIN_Q31);
        x = (x * gain) >>> 31;
        y = (y * gain) >>> 31;
        ox = x[31:0];
        oy = y[31:0];
    endfunction

    // Note an accepted sample; queue the pose it should produce.
    function void note_sample(logic [31:0] cnt [4], logic [31:0] stamp);
        longint       d [4];
        longint       sx, sy, st;
        logic [31:0]  diff, dt, dxw, dyw, rx, ry;
        logic [127:0] tk, lt, r, px, py, pt, q;
        t_result      res;
        if (!primed) begin
            foreach (cnt[k]) last_count[k] = cnt[k];
            last_stamp = stamp;
            primed = 1;
            return;
        end
        foreach (cnt[k]) begin
            diff = cnt[k] - last_count[k];
            d[k] = longint'($signed(diff));
            last_count[k] = cnt[k];
        end
        dt = stamp - last_stamp;
        last_stamp = stamp;
        sx = d[0] + d[1] + d[2] + d[3];
        sy = -d[0] + d[1] + d[2] - d[3];
        st = -d[0] + d[1] - d[2] + d[3];
        tk = (ticks == 0) ? 128'd1 : 128'(ticks);
        lt = ((half_track == 0) ? 128'd1 : 128'(half_track)) * tk;
        r  = 128'(radius);
        px = r * 128'(magnitude(sx)) * 128'(TWO_PI_Q29);
        py = r * 128'(magnitude(sy)) * 128'(TWO_PI_Q29);
        pt = r * 128'(magnitude(st)) * 128'(TWO_PI_Q29);
        q = (px / tk) >> DX_SHIFT;
        dxw = (sx < 0) ? 32'd0 - q[31:0] : q[31:0];
        q = (py / tk) >> DX_SHIFT;
        dyw = (sy < 0) ? 32'd0 - q[31:0] : q[31:0];
        res = '0;
        if (dt != 0) begin
            res.vel_x = clamp32((((px * 128'(US_PER_S)) / tk) / 128'(dt)) >> DX_SHIFT, sx < 0);
            res.vel_y = clamp32((((py * 128'(US_PER_S)) / tk) / 128'(dt)) >> DX_SHIFT, sy < 0);
            res.turn_rate =
                clamp32((((pt * 128'(US_PER_S)) / lt) / 128'(dt)) >> VT_SHIFT, st < 0);
        end
        turn_vector(dxw, dyw, heading, rx, ry);
        pose_x += rx;
        pose_y += ry;
        q = ((r * 128'(magnitude(st))) << 30) / lt;
        heading += (st < 0) ? 32'd0 - q[31:0] : q[31:0];
        res.pos_x   = pose_x;
        res.pos_y   = pose_y;
        res.heading = heading[31:16];
        res.time_us = stamp;
        expected_q.push_back(res);
    endfunction

    function void compare(string field, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s mismatch: expected %h, got %h", field, exp_v, got_v);
            failures++;
        end
    endfunction

    // Check one accepted result against the oldest expectation.
    function void check_result(t_result got);
        t_result exp_r;
        if (expected_q.size() == 0) begin
            $error("unexpected result: pos_x %h pos_y %h", got.pos_x, got.pos_y);
            failures++;
            return;
        end
        exp_r = expected_q.pop_front();
        compare("position_x", exp_r.pos_x, got.pos_x);
        compare("position_y", exp_r.pos_y, got.pos_y);
        compare("heading_angle", 32'(exp_r.heading), 32'(got.heading));
        compare("body_velocity_x", exp_r.vel_x, got.vel_x);
        compare("body_velocity_y", exp_r.vel_y, got.vel_y);
        compare("turn_rate", exp_r.turn_rate, got.turn_rate);
        compare("result_time_us", exp_r.time_us, got.time_us);
    endfunction
endclass

module mecanum_wheel_odometry_core_test;

    localparam int SETTLE_CYCLES = 900;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [159:0] i_s_axis_tdata;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [207:0] o_m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [17:0]  i_cfg_data;

    odometry_scoreboard pose_board;

    // Idle percentages for sender gaps and receiver stalls; changed per phase.
    int unsigned gap_pct;
    int unsigned stall_pct;

    // Running encoder counts and timestamp that well-formed samples advance from.
    logic [31:0] wheel_count [4];
    logic [31:0] clock_us;

    mecanum_wheel_odometry_core i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Stall the receiver at random; change ready only on the falling edge.
    always @(negedge i_clk) begin
        i_m_axis_tready = !(i_rst_n && ($urandom_range(99) < stall_pct));
    end

    // Check every accepted result, sampled at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            pose_board.check_result(t_result'(o_m_axis_tdata));
        end
    end

    // Write one register; the channel is idle whenever this is called.
    task automatic write_reg(logic [1:0] idx, logic [17:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        pose_board.write_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Send one sample request; valid stays high into the next call unless it idles.
    task automatic send_sample(logic [31:0] cnt [4], logic [31:0] stamp);
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = {stamp, cnt[3], cnt[2], cnt[1], cnt[0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
        pose_board.note_sample(cnt, stamp);
        @(negedge i_clk);
    endtask

    // Advance the wheels by the given deltas and the clock by dt, then send.
    task automatic step_wheels(int d0, int d1, int d2, int d3, logic [31:0] dt);
        wheel_count[0] += d0;
        wheel_count[1] += d1;
        wheel_count[2] += d2;
        wheel_count[3] += d3;
        clock_us += dt;
        send_sample(wheel_count, clock_us);
    endtask

    // Hold the sender until every expected result has come, then let the core settle.
    task automatic drain();
        i_s_axis_tvalid = 1'b0;
        while (pose_board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Mostly well-formed motion with random content; some wide jumps and noise.
    task automatic random_sample();
        int unsigned pick;
        int          span;
        pick = $urandom_range(99);
        if (pick < 10) begin
            // Noise: every field fully random, counts and time jump anywhere.
            foreach (wheel_count[k]) wheel_count[k] = $urandom;
            clock_us = $urandom;
            send_sample(wheel_count, clock_us);
        end else if (pick < 18) begin
            // Large displacement and tiny or zero elapsed time.
            step_wheels($urandom, $urandom, $urandom, $urandom, $urandom_range(3));
        end else begin
            span = ($urandom_range(3) == 0) ? 30000 : 2000;
            step_wheels($urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                        $urandom_range(2 * span) - span, $urandom_range(2 * span) - span,
                        ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 20000));
        end
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 84; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 84; end
            default: begin gap_pct = 24; stall_pct = 24; end
        endcase
    endtask

    // Pick a register setting for a phase: extremes first, then random.
    task automatic configure(int phase);
        case (phase)
            0: begin
                write_reg(CFG_TICKS, 18'd1);
                write_reg(CFG_RADIUS, 18'd1);
                write_reg(CFG_HALF_TRACK, 18'd1);
            end
            1: begin
                write_reg(CFG_TICKS, 18'd65535);
                write_reg(CFG_RADIUS, 18'd65535);
                write_reg(CFG_HALF_TRACK, 18'd262143);
            end
            2: begin
                // Zero ticks and zero half-track act as one.
                write_reg(CFG_TICKS, 18'd0);
                write_reg(CFG_RADIUS, 18'd40000);
                write_reg(CFG_HALF_TRACK, 18'd0);
            end
            3: begin
                write_reg(CFG_TICKS, 18'd1);
                write_reg(CFG_RADIUS, 18'd65535);
                write_reg(CFG_HALF_TRACK, 18'd1);
            end
            default: begin
                write_reg(CFG_TICKS, 18'($urandom_range(1, 65535)));
                write_reg(CFG_RADIUS, 18'($urandom_range(1, 65535)));
                write_reg(CFG_HALF_TRACK, 18'($urandom_range(1, 262143)));
            end
        endcase
    endtask

    initial begin
        logic [31:0] edge_cnt [4];
        pose_board      = new();
        gap_pct         = 0;
        stall_pct       = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_m_axis_tready = 1'b1;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_TICKS;
        i_cfg_data      = '0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Defaults rewritten, the upper data bits of a 16-bit register dropped,
        // and an index beyond the last register ignored.
        write_reg(CFG_TICKS, 18'h301F4);
        write_reg(CFG_RADIUS, 18'd3277);
        write_reg(CFG_HALF_TRACK, 18'd22938);
        write_reg(2'd3, 18'h3FFFF);

        // Directed: prime on extreme counts, then single wheels, pure strafe and
        // spin, extreme count jumps, zero and wrapping elapsed time.
        edge_cnt = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0};
        wheel_count = edge_cnt;
        clock_us = 32'hFFFF_FF00;
        send_sample(wheel_count, clock_us);          // primes only, no result
        step_wheels(0, 0, 0, 0, 32'd1000);          // no motion, time wraps
        step_wheels(1, 0, 0, 0, 32'd1);
        step_wheels(0, 1, 0, 0, 32'd1);
        step_wheels(0, 0, 1, 0, 32'd1);
        step_wheels(0, 0, 0, 1, 32'd1);
        step_wheels(-100, 100, 100, -100, 32'd500); // sideways
        step_wheels(-4000, 4000, -4000, 4000, 32'd0); // spin, zero elapsed time
        step_wheels(4000, 4000, 4000, 4000, 32'd1000);
        for (int i = 0; i < 4; i++)
            step_wheels(-30000, 30000, -30000, 30000, 32'd2000); // sweep quarters
        step_wheels(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
        step_wheels(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1);
        step_wheels(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd1);
        step_wheels(-7, -7, -7, -7, 32'hFFFF_FFFF);
        step_wheels(0, 0, 0, 0, 32'd0);
        send_sample('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                    32'hFFFF_FFFF);
        send_sample('{32'h0, 32'h0, 32'h0, 32'h0}, 32'h0);
        wheel_count = '{32'h0, 32'h0, 32'h0, 32'h0};
        clock_us = 32'h0;

        // Random phases, each with its own idling mode and register setting.
        for (int phase = 0; phase < 6; phase++) begin
            drain();
            configure(phase);
            set_idling(phase);
            for (int n = 0; n < 100; n++) begin
                // Hold off once until the core has emptied out.
                if (phase == 2 && n == 50) begin
                    i_s_axis_tvalid = 1'b0;
                    while (pose_board.pending() != 0) @(negedge i_clk);
                end
                random_sample();
            end
        end

        i_s_axis_tvalid = 1'b0;
        stall_pct = 24;
        while (pose_board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (pose_board.failures == 0 && pose_board.pending() == 0) begin
            $display("mecanum_wheel_odometry_core_test: PASS");
        end else begin
            $display("mecanum_wheel_odometry_core_test: FAIL");
        end
        $finish;
    end

    // Guard against a hang: well beyond the slowest legal run.
    initial begin
        #60ms;
        $display("mecanum_wheel_odometry_core_test: FAIL");
        $finish;
    end

endmodule
